// File: sv/gcode_line_parser_assert.svh
// Assertion macros for the G-code line parser RTL
`ifndef GCODE_LINE_PARSER_ASSERT_SVH
`define GCODE_LINE_PARSER_ASSERT_SVH
`ifndef SYNTHESIS
`define GCL_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
`define GCL_NEVER(label, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) !(expr)) else $error(msg);
`else
`define GCL_ASSERT(label, prop, msg)
`define GCL_NEVER(label, expr, msg)
`endif
`endif

// File: sv/gcl_pkg.sv
// Shared types, constants and helper functions of the G-code line parser
`default_nettype none
package gcl_pkg;

   localparam int MAX_LINE  = 255;
   localparam int CHAR_W    = $clog2(MAX_LINE + 1);
   localparam int NUM_WORDS = 5;
   localparam int K_W       = 14;
   localparam int A_W       = 14;
   localparam int MAG_W     = 32 + K_W;

   localparam logic [7:0] CH_G     = 8'h47;
   localparam logic [7:0] CH_M     = 8'h4D;
   localparam logic [7:0] CH_X     = 8'h58;
   localparam logic [7:0] CH_Y     = 8'h59;
   localparam logic [7:0] CH_Z     = 8'h5A;
   localparam logic [7:0] CH_S     = 8'h53;
   localparam logic [7:0] CH_F     = 8'h46;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_DOT   = 8'h2E;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;
   localparam logic [7:0] CH_NUL   = 8'h00;

   localparam logic [2:0] SLOT_NONE = 3'd0;
   localparam logic [2:0] SLOT_X    = 3'd1;
   localparam logic [2:0] SLOT_Y    = 3'd2;
   localparam logic [2:0] SLOT_Z    = 3'd3;
   localparam logic [2:0] SLOT_S    = 3'd4;
   localparam logic [2:0] SLOT_F    = 3'd5;

   typedef enum logic [2:0] {
      PH_LEAD,
      PH_CODE,
      PH_SKIP,
      PH_GAP,
      PH_VALUE,
      PH_DEAD
   } phase_type;

   typedef enum logic [1:0] {
      NS_FRESH,
      NS_BLANK,
      NS_INT,
      NS_FRAC
   } num_stage_type;

   typedef struct packed {
      phase_type                      phase;
      logic [CHAR_W-1:0]              chars;
      logic [31:0]                    acc;
      logic                           neg;
      logic [1:0]                     frac_cnt;
      num_stage_type                  stage;
      logic [2:0]                     letter;
      logic                           seen_cmd;
      logic                           cmd_m;
      logic [15:0]                    code;
      logic [NUM_WORDS-1:0][31:0]     values;
      logic [NUM_WORDS-1:0]           mask;
   } line_state_type;

   typedef struct packed {
      logic                           command_letter;
      logic [15:0]                    code_number;
      logic [NUM_WORDS-1:0][31:0]     values;
      logic [NUM_WORDS-1:0]           present_mask;
      logic                           line_valid;
   } line_result_type;

   typedef struct packed {
      logic [31:0]    base;
      logic [K_W-1:0] mult;
      logic [A_W-1:0] addend;
      logic           neg;
   } commit_req_type;

   function automatic logic [2:0] letter_slot(input logic [7:0] c);
      logic [2:0] slot;
      unique case (c)
         CH_X:    slot = SLOT_X;
         CH_Y:    slot = SLOT_Y;
         CH_Z:    slot = SLOT_Z;
         CH_S:    slot = SLOT_S;
         CH_F:    slot = SLOT_F;
         default: slot = SLOT_NONE;
      endcase
      return slot;
   endfunction

   // thousandths scale for a given number of fraction digits
   function automatic logic [K_W-1:0] frac_scale(input logic [1:0] fc);
      logic [K_W-1:0] k;
      unique case (fc)
         2'd0:    k = K_W'(1000);
         2'd1:    k = K_W'(100);
         2'd2:    k = K_W'(10);
         default: k = K_W'(1);
      endcase
      return k;
   endfunction

endpackage
`default_nettype wire

// File: sv/gcl_value_unit.sv
// Scales a parsed magnitude and saturates it to the code and value ranges
`default_nettype none
module gcl_value_unit (
   input  gcl_pkg::commit_req_type req,
   output logic [15:0]             val16,
   output logic [31:0]             val32
);
   import gcl_pkg::*;

   logic [MAG_W-1:0] mag;
   logic [31:0]      lim32;
   logic [16:0]      lim16;

   assign mag = MAG_W'(req.base) * MAG_W'(req.mult) + MAG_W'(req.addend);

   always_comb begin
      if (req.neg) begin
         lim32 = (mag > MAG_W'(33'h0_8000_0000)) ? 32'h8000_0000 : mag[31:0];
         val32 = 32'd0 - lim32;
         lim16 = (mag > MAG_W'(32768)) ? 17'd32768 : mag[16:0];
         val16 = 16'(17'd0 - lim16);
      end else begin
         lim32 = (mag > MAG_W'(32'h7FFF_FFFF)) ? 32'h7FFF_FFFF : mag[31:0];
         val32 = lim32;
         lim16 = (mag > MAG_W'(32767)) ? 17'd32767 : mag[16:0];
         val16 = lim16[15:0];
      end
   end

endmodule
`default_nettype wire

// File: sv/gcl_line_core.sv
// Per-character parse state, next-state logic and line result formation
`default_nettype none
`include "gcode_line_parser_assert.svh"
module gcl_line_core (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     step,
   input  logic [7:0]               ch,
   output logic                     res_valid,
   output gcl_pkg::line_result_type res
);
   import gcl_pkg::*;

   localparam line_state_type LINE_CLEAR = '0;

   line_state_type st_ff, st_in, s_end;
   commit_req_type creq;
   logic [15:0]    v16;
   logic [31:0]    v32;
   logic           fin;
   logic           is_eol, is_digit, is_sign, is_blank, num_phase, early;
   logic [3:0]     dig;
   logic [35:0]    acc_t;
   logic [31:0]    acc_dig;

   function automatic line_state_type apply_commit(input line_state_type s,
                                                   input logic [15:0] c16,
                                                   input logic [31:0] c32);
      line_state_type r;
      logic [2:0]     idx;
      r   = s;
      idx = 3'(s.letter - 3'd1);
      if (s.phase == PH_CODE) begin
         r.code = c16;
      end else if (s.letter != SLOT_NONE && s.letter <= SLOT_F) begin
         r.values[idx] = c32;
         r.mask[idx]   = 1'b1;
      end
      return r;
   endfunction

   function automatic line_state_type begin_word(input line_state_type s,
                                                 input logic [7:0] c);
      line_state_type r;
      r          = s;
      r.letter   = letter_slot(c);
      r.phase    = PH_VALUE;
      r.acc      = '0;
      r.neg      = 1'b0;
      r.frac_cnt = '0;
      r.stage    = NS_FRESH;
      return r;
   endfunction

   assign is_eol    = (ch == CH_CR) || (ch == CH_LF);
   assign is_digit  = (ch >= CH_ZERO) && (ch <= CH_NINE);
   assign is_sign   = (ch == CH_PLUS) || (ch == CH_MINUS);
   assign is_blank  = (ch == CH_SPACE) || (ch == CH_TAB);
   assign num_phase = (st_ff.phase == PH_CODE) || (st_ff.phase == PH_VALUE);
   assign early     = (st_ff.stage == NS_FRESH) || (st_ff.stage == NS_BLANK);
   assign dig       = ch[3:0];

   assign acc_t   = 36'({st_ff.acc, 3'b000}) + 36'({st_ff.acc, 1'b0}) + 36'(dig);
   assign acc_dig = (acc_t[35:32] != 4'd0) ? 32'hFFFF_FFFF : acc_t[31:0];

   // scaling request: folds a digit taken this cycle into the multiply
   always_comb begin
      creq.base   = st_ff.acc;
      creq.neg    = (is_sign && early) ? (ch == CH_MINUS) : st_ff.neg;
      creq.mult   = (st_ff.phase == PH_CODE) ? K_W'(1) : frac_scale(st_ff.frac_cnt);
      creq.addend = '0;
      if (is_digit) begin
         if (st_ff.phase == PH_CODE) begin
            creq.mult   = K_W'(10);
            creq.addend = A_W'(dig);
         end else if (st_ff.stage != NS_FRAC) begin
            creq.mult   = K_W'(10000);
            creq.addend = A_W'(dig) * A_W'(1000);
         end else begin
            unique case (st_ff.frac_cnt)
               2'd0: begin
                  creq.mult   = K_W'(1000);
                  creq.addend = A_W'(dig) * A_W'(100);
               end
               2'd1: begin
                  creq.mult   = K_W'(100);
                  creq.addend = A_W'(dig) * A_W'(10);
               end
               2'd2: begin
                  creq.mult   = K_W'(10);
                  creq.addend = A_W'(dig);
               end
               default: begin
                  creq.mult   = K_W'(1);
                  creq.addend = '0;
               end
            endcase
         end
      end
   end

   gcl_value_unit u_value (
      .req   (creq),
      .val16 (v16),
      .val32 (v32)
   );

   always_comb begin : next_state
      line_state_type s;
      logic           fresh;
      s     = st_ff;
      fresh = 1'b0;
      fin   = 1'b0;
      if (step) begin
         if (is_eol) begin
            if (num_phase) begin
               s = apply_commit(s, v16, v32);
            end
            fin = 1'b1;
         end else begin
            s.chars = st_ff.chars + CHAR_W'(1);
            unique case (st_ff.phase)
               PH_LEAD: begin
                  if (is_blank) begin
                     s.phase = PH_LEAD;
                  end else if (ch == CH_G || ch == CH_M) begin
                     s.seen_cmd = 1'b1;
                     s.cmd_m    = (ch == CH_M);
                     s.phase    = PH_CODE;
                     fresh      = 1'b1;
                  end else begin
                     s.phase = PH_DEAD;
                  end
               end
               PH_CODE, PH_VALUE: begin
                  if (is_digit) begin
                     if (st_ff.stage == NS_FRAC) begin
                        if (st_ff.frac_cnt != 2'd3) begin
                           s.acc      = acc_dig;
                           s.frac_cnt = st_ff.frac_cnt + 2'd1;
                        end
                     end else begin
                        s.acc   = acc_dig;
                        s.stage = NS_INT;
                     end
                  end else if (is_sign && early) begin
                     s.neg   = (ch == CH_MINUS);
                     s.stage = NS_INT;
                  end else if (ch == CH_DOT && st_ff.phase == PH_VALUE &&
                               st_ff.stage != NS_FRAC) begin
                     s.stage = NS_FRAC;
                  end else if (is_blank && early) begin
                     s.stage = NS_BLANK;
                  end else begin
                     s = apply_commit(s, v16, v32);
                     if (ch == CH_NUL) begin
                        s.phase = PH_DEAD;
                     end else if (st_ff.stage == NS_BLANK) begin
                        s     = begin_word(s, ch);
                        fresh = 1'b1;
                     end else if (ch == CH_SPACE) begin
                        s.phase = PH_GAP;
                     end else begin
                        s.phase = PH_SKIP;
                     end
                  end
               end
               PH_SKIP: begin
                  if (ch == CH_SPACE) begin
                     s.phase = PH_GAP;
                  end else if (ch == CH_NUL) begin
                     s.phase = PH_DEAD;
                  end
               end
               PH_GAP: begin
                  if (ch == CH_NUL) begin
                     s.phase = PH_DEAD;
                  end else if (ch != CH_SPACE) begin
                     s     = begin_word(s, ch);
                     fresh = 1'b1;
                  end
               end
               default: begin
                  s.phase = st_ff.phase;
               end
            endcase
            if (s.chars == CHAR_W'(MAX_LINE)) begin
               fin = 1'b1;
               if (s.phase == PH_CODE || s.phase == PH_VALUE) begin
                  s = apply_commit(s, fresh ? 16'd0 : v16, fresh ? 32'd0 : v32);
               end
            end
         end
      end
      s_end = s;
      st_in = fin ? LINE_CLEAR : s;
   end

   always_comb begin : result_form
      res_valid          = fin;
      res.command_letter = s_end.seen_cmd & s_end.cmd_m;
      res.code_number    = s_end.code;
      res.values         = s_end.values;
      res.present_mask   = s_end.mask;
      res.line_valid     = s_end.seen_cmd;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= LINE_CLEAR;
      end else begin
         st_ff <= st_in;
      end
   end

   `GCL_NEVER(a_chars_below_max, st_ff.chars >= CHAR_W'(MAX_LINE), "line count past limit")
   `GCL_NEVER(a_mask_needs_cmd, st_ff.mask != '0 && !st_ff.seen_cmd, "word without command")
   `GCL_NEVER(a_lead_no_cmd, st_ff.phase == PH_LEAD && st_ff.seen_cmd, "command in lead phase")
   `GCL_ASSERT(a_end_clears, step && res_valid |=> st_ff.chars == '0 && st_ff.phase == PH_LEAD, "line end did not clear")

endmodule
`default_nettype wire

// File: sv/gcode_line_parser.sv
// Top level of the G-code line parser: input register, parse core, result register
// A line-ending character waits in the input register; its line result is registered.
// Throughput: one character per cycle; a result that is not taken stalls the core, and
// the input register holds one more character before req_ready drops.
// Reset: synchronous, active high; clears the parse state and both valid flags.
`default_nettype none
`include "gcode_line_parser_assert.svh"
module gcode_line_parser (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [7:0]         req_ch,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic               rsp_command_letter,
   output logic signed [15:0] rsp_code_number,
   output logic signed [31:0] rsp_x_value,
   output logic signed [31:0] rsp_y_value,
   output logic signed [31:0] rsp_z_value,
   output logic signed [31:0] rsp_s_value,
   output logic signed [31:0] rsp_f_value,
   output logic [4:0]         rsp_present_mask,
   output logic               rsp_line_valid
);
   import gcl_pkg::*;

   logic            in_valid_ff, in_valid_in;
   logic [7:0]      in_ch_ff;
   logic            rsp_valid_ff, rsp_valid_in;
   line_result_type rsp_ff;
   line_result_type core_res;
   logic            core_res_valid;
   logic            advance;

   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   gcl_line_core u_core (
      .clock     (clock),
      .reset     (reset),
      .step      (advance),
      .ch        (in_ch_ff),
      .res_valid (core_res_valid),
      .res       (core_res)
   );

   always_comb begin
      in_valid_in = req_valid ? 1'b1 : (in_valid_ff && !advance);
      if (advance) begin
         rsp_valid_in = core_res_valid;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_ready) begin
            in_valid_ff <= in_valid_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_ch_ff <= req_ch;
      end
      if (advance && core_res_valid) begin
         rsp_ff <= core_res;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_command_letter = rsp_ff.command_letter;
   assign rsp_code_number    = rsp_ff.code_number;
   assign rsp_x_value        = rsp_ff.values[0];
   assign rsp_y_value        = rsp_ff.values[1];
   assign rsp_z_value        = rsp_ff.values[2];
   assign rsp_s_value        = rsp_ff.values[3];
   assign rsp_f_value        = rsp_ff.values[4];
   assign rsp_present_mask   = rsp_ff.present_mask;
   assign rsp_line_valid     = rsp_ff.line_valid;

   `GCL_NEVER(a_no_overwrite, req_valid && req_ready && in_valid_ff && !advance, "input register overrun")
   `GCL_ASSERT(a_hold_input, in_valid_ff && !advance |=> in_valid_ff && $stable(in_ch_ff), "stalled character lost")
   `GCL_ASSERT(a_result_loaded, advance && core_res_valid |=> rsp_valid_ff, "line result dropped")

endmodule
`default_nettype wire

// File: tb/gcode_line_parser_test.sv
// Self-checking testbench for gcode_line_parser: directed lines, then random traffic
module gcode_line_parser_test;
   timeunit 1ns;
   timeprecision 1ps;
   import gcl_pkg::*;

   localparam int HOLD_CYCLES  = 120;
   localparam int STALL_LIMIT  = 2000;
   localparam int DRAIN_CYCLES = 10;
   localparam int PHASE_CHARS  = 140;
   localparam logic [7:0] WORD_CHARS [5] = '{CH_X, CH_Y, CH_Z, CH_S, CH_F};

   typedef struct packed {
      logic        cmd_m;
      logic [15:0] code;
      logic [31:0] x;
      logic [31:0] y;
      logic [31:0] z;
      logic [31:0] s;
      logic [31:0] f;
      logic [4:0]  mask;
      logic        valid;
   } parsed_line_type;

   typedef struct {
      string           text;
      bit              typed;
      parsed_line_type want;
   } line_row_type;

   logic               clock     = 1'b0;
   logic               reset     = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic [7:0]         req_ch    = 8'h00;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic               rsp_command_letter;
   logic signed [15:0] rsp_code_number;
   logic signed [31:0] rsp_x_value;
   logic signed [31:0] rsp_y_value;
   logic signed [31:0] rsp_z_value;
   logic signed [31:0] rsp_s_value;
   logic signed [31:0] rsp_f_value;
   logic [4:0]         rsp_present_mask;
   logic               rsp_line_valid;

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   bit squeeze_on    = 1'b0;
   int fault_count   = 0;
   int idle_cycles   = 0;

   parsed_line_type pending_lines [$];
   logic [7:0]      char_feed [$];
   line_row_type    rows [$];

   // line parser state
   phase_type     lp_phase;
   int            lp_chars;
   logic [31:0]   lp_acc;
   logic          lp_neg;
   int            lp_frac;
   num_stage_type lp_stage;
   int            lp_slot;
   logic          lp_seen_cmd;
   logic          lp_cmd_m;
   logic [15:0]   lp_code;
   logic [31:0]   lp_vals [5];
   logic [4:0]    lp_mask;

   gcode_line_parser u_top (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_ch             (req_ch),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_command_letter (rsp_command_letter),
      .rsp_code_number    (rsp_code_number),
      .rsp_x_value        (rsp_x_value),
      .rsp_y_value        (rsp_y_value),
      .rsp_z_value        (rsp_z_value),
      .rsp_s_value        (rsp_s_value),
      .rsp_f_value        (rsp_f_value),
      .rsp_present_mask   (rsp_present_mask),
      .rsp_line_valid     (rsp_line_valid)
   );

   always #6 clock = ~clock;

   function automatic void reset_number();
      lp_acc   = '0;
      lp_neg   = 1'b0;
      lp_frac  = 0;
      lp_stage = NS_FRESH;
   endfunction

   function automatic void clear_line();
      lp_phase = PH_LEAD;
      lp_chars = 0;
      reset_number();
      lp_slot     = 0;
      lp_seen_cmd = 1'b0;
      lp_cmd_m    = 1'b0;
      lp_code     = '0;
      foreach (lp_vals[i]) lp_vals[i] = '0;
      lp_mask = '0;
   endfunction

   function automatic void push_digit(input logic [7:0] d);
      logic [63:0] t;
      t = {32'd0, lp_acc} * 64'd10 + {56'd0, d};
      lp_acc = (t > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : t[31:0];
   endfunction

   function automatic logic [31:0] clamp_signed(input logic [63:0] mag,
                                                input logic [63:0] pos_lim);
      if (lp_neg) begin
         if (mag > pos_lim + 64'd1) mag = pos_lim + 64'd1;
         mag = 64'd0 - mag;
         return mag[31:0];
      end
      if (mag > pos_lim) mag = pos_lim;
      return mag[31:0];
   endfunction

   function automatic void commit_number();
      logic [63:0] mag;
      logic [31:0] wide;
      if (lp_phase == PH_CODE) begin
         wide    = clamp_signed({32'd0, lp_acc}, 64'd32767);
         lp_code = wide[15:0];
      end else if (lp_slot >= 1 && lp_slot <= 5) begin
         case (lp_frac)
            0: mag = {32'd0, lp_acc} * 64'd1000;
            1: mag = {32'd0, lp_acc} * 64'd100;
            2: mag = {32'd0, lp_acc} * 64'd10;
            default: mag = {32'd0, lp_acc};
         endcase
         lp_vals[lp_slot-1] = clamp_signed(mag, 64'd2147483647);
         lp_mask[lp_slot-1] = 1'b1;
      end
   endfunction

   function automatic int word_slot(input logic [7:0] c);
      case (c)
         CH_X: return 1;
         CH_Y: return 2;
         CH_Z: return 3;
         CH_S: return 4;
         CH_F: return 5;
         default: return 0;
      endcase
   endfunction

   function automatic void open_word(input logic [7:0] c);
      lp_slot  = word_slot(c);
      lp_phase = PH_VALUE;
      reset_number();
   endfunction

   function automatic void number_char(input logic [7:0] c);
      num_stage_type st;
      st = lp_stage;
      if (c >= CH_ZERO && c <= CH_NINE) begin
         if (st == NS_FRAC) begin
            if (lp_frac < 3) begin
               push_digit(c - CH_ZERO);
               lp_frac++;
            end
         end else begin
            push_digit(c - CH_ZERO);
            lp_stage = NS_INT;
         end
      end else if ((c == CH_PLUS || c == CH_MINUS) && st < NS_INT) begin
         lp_neg   = (c == CH_MINUS);
         lp_stage = NS_INT;
      end else if (c == CH_DOT && lp_phase == PH_VALUE && st != NS_FRAC) begin
         lp_stage = NS_FRAC;
      end else if ((c == CH_SPACE || c == CH_TAB) && st < NS_INT) begin
         lp_stage = NS_BLANK;
      end else begin
         commit_number();
         if (c == CH_NUL) lp_phase = PH_DEAD;
         else if (st == NS_BLANK) open_word(c);
         else if (c == CH_SPACE) lp_phase = PH_GAP;
         else lp_phase = PH_SKIP;
      end
   endfunction

   function automatic parsed_line_type finish_line();
      parsed_line_type r;
      if (lp_phase == PH_CODE || lp_phase == PH_VALUE) commit_number();
      r.cmd_m = lp_seen_cmd & lp_cmd_m;
      r.code  = lp_code;
      r.x     = lp_vals[0];
      r.y     = lp_vals[1];
      r.z     = lp_vals[2];
      r.s     = lp_vals[3];
      r.f     = lp_vals[4];
      r.mask  = lp_mask;
      r.valid = lp_seen_cmd;
      clear_line();
      return r;
   endfunction

   function automatic bit parse_char(input logic [7:0] c, output parsed_line_type r);
      if (c == CH_CR || c == CH_LF) begin
         r = finish_line();
         return 1'b1;
      end
      lp_chars++;
      case (lp_phase)
         PH_LEAD: begin
            if (c == CH_G || c == CH_M) begin
               lp_seen_cmd = 1'b1;
               lp_cmd_m    = (c == CH_M);
               lp_phase    = PH_CODE;
               reset_number();
            end else if (c != CH_SPACE && c != CH_TAB) begin
               lp_phase = PH_DEAD;
            end
         end
         PH_CODE, PH_VALUE: number_char(c);
         PH_SKIP: begin
            if (c == CH_SPACE) lp_phase = PH_GAP;
            else if (c == CH_NUL) lp_phase = PH_DEAD;
         end
         PH_GAP: begin
            if (c == CH_NUL) lp_phase = PH_DEAD;
            else if (c != CH_SPACE) open_word(c);
         end
         default: ;
      endcase
      if (lp_chars >= MAX_LINE) begin
         r = finish_line();
         return 1'b1;
      end
      r = '0;
      return 1'b0;
   endfunction

   function automatic parsed_line_type line_of(input logic cmd_m, input logic [15:0] code,
                                               input logic [31:0] x, y, z, s, f,
                                               input logic [4:0] mask);
      parsed_line_type r;
      r.cmd_m = cmd_m;
      r.code  = code;
      r.x     = x;
      r.y     = y;
      r.z     = z;
      r.s     = s;
      r.f     = f;
      r.mask  = mask;
      r.valid = 1'b1;
      return r;
   endfunction

   task automatic add_row(input string text, input bit typed = 1'b0,
                          input parsed_line_type want = '0);
      line_row_type row;
      row.text  = text;
      row.typed = typed;
      row.want  = want;
      rows.push_back(row);
   endtask

   task automatic push_digits(input int n);
      repeat (n) char_feed.push_back(8'(CH_ZERO + $urandom_range(0, 9)));
   endtask

   task automatic push_number(input bit allow_frac);
      if ($urandom_range(0, 19) == 0)
         repeat ($urandom_range(1, 2)) char_feed.push_back(CH_SPACE);
      case ($urandom_range(0, 9))
         0, 1, 2: char_feed.push_back(CH_MINUS);
         3: char_feed.push_back(CH_PLUS);
         default: ;
      endcase
      push_digits(($urandom_range(0, 19) == 0) ? $urandom_range(6, 14) : $urandom_range(0, 4));
      if ($urandom_range(0, 9) < (allow_frac ? 5 : 1)) begin
         char_feed.push_back(CH_DOT);
         push_digits($urandom_range(0, 5));
      end
      if ($urandom_range(0, 19) == 0) char_feed.push_back(8'($urandom_range(0, 255)));
   endtask

   task automatic append_line();
      int pick;
      if ($urandom_range(0, 9) == 0) begin
         repeat ($urandom_range(1, 20)) char_feed.push_back(8'($urandom_range(0, 255)));
         char_feed.push_back(CH_LF);
         return;
      end
      repeat ($urandom_range(0, 2))
         char_feed.push_back($urandom_range(0, 1) ? CH_SPACE : CH_TAB);
      pick = $urandom_range(0, 19);
      if (pick == 0) char_feed.push_back(8'($urandom_range(0, 255)));
      else char_feed.push_back(pick < 11 ? CH_G : CH_M);
      push_number(1'b0);
      repeat ($urandom_range(0, 5)) begin
         pick = $urandom_range(0, 19);
         char_feed.push_back(pick == 0 ? CH_TAB : CH_SPACE);
         if (pick == 1) char_feed.push_back(CH_SPACE);
         pick = $urandom_range(0, 9);
         if (pick < 8) char_feed.push_back(WORD_CHARS[$urandom_range(0, 4)]);
         else if (pick == 8) char_feed.push_back(8'($urandom_range(8'h41, 8'h5A)));
         else char_feed.push_back(CH_TAB);
         push_number(1'b1);
      end
      // long line, cut by the length limit once it reaches MAX_LINE characters
      if ($urandom_range(0, 49) == 0) push_digits($urandom_range(240, 300));
      pick = $urandom_range(0, 9);
      if (pick < 4) begin
         char_feed.push_back(CH_LF);
      end else if (pick < 8) begin
         char_feed.push_back(CH_CR);
      end else begin
         char_feed.push_back(CH_CR);
         char_feed.push_back(CH_LF);
      end
   endtask

   task automatic send_char(input logic [7:0] c, input bit typed,
                            input parsed_line_type want);
      parsed_line_type predicted;
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_ch    <= c;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      if (parse_char(c, predicted)) pending_lines.push_back(typed ? want : predicted);
   endtask

   function automatic void check_field(input string name, input logic [31:0] want,
                                       input logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", name, $signed(want), $signed(got));
         fault_count++;
      end
   endfunction

   initial begin : rx_side
      int hold_count;
      parsed_line_type want;
      hold_count = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready) begin
            if (pending_lines.size() == 0) begin
               $error("line result with no line pending");
               fault_count++;
            end else begin
               want = pending_lines.pop_front();
               check_field("command_letter", 32'(want.cmd_m), 32'(rsp_command_letter));
               check_field("code_number", {{16{want.code[15]}}, want.code},
                           {{16{rsp_code_number[15]}}, rsp_code_number});
               check_field("x_value", want.x, rsp_x_value);
               check_field("y_value", want.y, rsp_y_value);
               check_field("z_value", want.z, rsp_z_value);
               check_field("s_value", want.s, rsp_s_value);
               check_field("f_value", want.f, rsp_f_value);
               check_field("present_mask", 32'(want.mask), 32'(rsp_present_mask));
               check_field("line_valid", 32'(want.valid), 32'(rsp_line_valid));
            end
         end
         if (squeeze_on && hold_count < HOLD_CYCLES) begin
            hold_count++;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin : tx_side
      string        wide_line;
      line_row_type row;
      int           n;
      clear_line();
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // '@' in these rows stands for a NUL byte
      add_row("\n", 1'b1, '0);
      add_row("G1 X-99999999\n", 1'b1, line_of(1'b0, 16'd1, 32'h8000_0000, 0, 0, 0, 0, 5'b00001));
      add_row("M99999\r", 1'b1, line_of(1'b1, 16'h7FFF, 0, 0, 0, 0, 0, 5'b00000));
      add_row("G-99999\n", 1'b1, line_of(1'b0, 16'h8000, 0, 0, 0, 0, 0, 5'b00000));
      add_row("G1 X2147483.647 Y-2147483.648\n", 1'b1,
              line_of(1'b0, 16'd1, 32'h7FFF_FFFF, 32'h8000_0000, 0, 0, 0, 5'b00011));
      add_row("M0 S99999999999999 F0\n", 1'b1,
              line_of(1'b1, 16'd0, 0, 0, 0, 32'h7FFF_FFFF, 0, 5'b11000));
      add_row("Q7 X1\n", 1'b1, '0);
      add_row("g1 X1\n", 1'b1, '0);
      add_row("  \tG01 X1.5 Y-2.25 Z+0.1234 S100 F3000.0\r");
      add_row("G1 X1 X-2\n");
      add_row("G0 X\n");
      add_row("G0 X  Y5\n");
      add_row("G0 X1\tY2 Z3\n");
      add_row("G0 X1 \tY2 Z3\n");
      add_row("G1.5 X2\n");
      add_row("G1 X1A2 Y3 B4\n");
      add_row("G1 X1@ Y2\n");
      add_row("M3 S+-5 F.5\r\n");
      add_row("G 28 X -1\n");
      wide_line = "G1";
      repeat (MAX_LINE - 2) wide_line = {wide_line, " "};
      add_row(wide_line, 1'b1, line_of(1'b0, 16'd1, 0, 0, 0, 0, 0, 5'b00000));

      send_idle_pct = 33;
      recv_idle_pct = 67;
      foreach (rows[r]) begin
         row = rows[r];
         n   = row.text.len();
         for (int i = 0; i < n; i++)
            send_char((row.text[i] == "@") ? CH_NUL : row.text[i],
                      row.typed && (i == n - 1), row.want);
      end

      for (int p = 0; p < 3; p++) begin
         case (p)
            0: begin
               send_idle_pct = 33;
               recv_idle_pct = 67;
            end
            1: begin
               send_idle_pct = 67;
               recv_idle_pct = 33;
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
               squeeze_on    = 1'b1;
            end
         endcase
         while (char_feed.size() < PHASE_CHARS) append_line();
         while (char_feed.size() != 0) send_char(char_feed.pop_front(), 1'b0, '0);
      end

      req_valid <= 1'b0;
      while (pending_lines.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fault_count == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
